### rtl/core/mbrs_pkg.sv
package mbrs_pkg;

  localparam int unsigned HDR_LEN   = 6;
  localparam int unsigned CMD_DEPTH = 2;
  localparam logic [3:0]  GAP_MAX   = 4'd15;
  localparam logic [3:0]  RESP_LAST = 4'd10;
  localparam logic [3:0]  CRC_FIRST = 4'd9;

  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_WRITE = 8'h06;
  localparam logic [7:0]  RESP_COUNT = 8'h06;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  localparam logic [1:0]  CFG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0]  CFG_GAP_THRESHOLD = 2'd1;

  localparam logic        OP_BYTE = 1'b0;
  localparam logic        OP_TICK = 1'b1;

  localparam logic [1:0]  REG_FIRST  = 2'd0;
  localparam logic [1:0]  REG_SECOND = 2'd1;
  localparam logic [1:0]  REG_MODE   = 2'd2;

  typedef enum logic {
    CMD_WRITE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] reg_sel;
    logic [7:0] data;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] din);
    logic [15:0] c;
    c = crc_in ^ {8'h00, din};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/mbrs_ifs.sv
interface mbrs_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mbrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;
  modport source (output valid, output tx_byte, output last_byte, input ready);
  modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

interface mbrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/mbrs_front.sv
module mbrs_front #(
  parameter int unsigned RX_COUNT_LIMIT = 255
) (
  input  logic               clk,
  input  logic               rst,
  mbrs_in_if.sink            items,
  input  logic [7:0]         slave_address,
  input  logic [3:0]         gap_threshold,
  input  logic               cmd_full,
  output logic               cmd_push,
  output mbrs_pkg::cmd_t     cmd_data
);

  logic [7:0] rx_count;
  logic [7:0] header_bytes [mbrs_pkg::HDR_LEN];
  logic [3:0] gap_count;
  logic [3:0] gap_next;
  logic       accept;
  logic       handle;
  logic       addr_hit;
  logic       reg_ok;

  assign items.ready = !cmd_full;
  assign accept      = items.valid && items.ready;

  assign gap_next = (gap_count < mbrs_pkg::GAP_MAX) ? gap_count + 4'd1 : gap_count;
  assign handle   = accept && (items.opcode == mbrs_pkg::OP_TICK) && (rx_count != 8'd0)
                    && (gap_next >= gap_threshold);
  assign addr_hit = header_bytes[0] == slave_address;
  assign reg_ok   = (header_bytes[2] == 8'd0) && (header_bytes[3] < 8'd3);

  always_comb begin
    cmd_push         = 1'b0;
    cmd_data.kind    = mbrs_pkg::CMD_WRITE;
    cmd_data.reg_sel = header_bytes[3][1:0];
    cmd_data.data    = header_bytes[5];
    if (handle && addr_hit) begin
      if (header_bytes[1] == mbrs_pkg::FUNC_WRITE) begin
        cmd_push = reg_ok;
      end else if (header_bytes[1] == mbrs_pkg::FUNC_READ) begin
        cmd_push      = 1'b1;
        cmd_data.kind = mbrs_pkg::CMD_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count  <= 8'd0;
      gap_count <= 4'd0;
      for (int i = 0; i < int'(mbrs_pkg::HDR_LEN); i++) begin
        header_bytes[i] <= 8'd0;
      end
    end else if (accept) begin
      if (items.opcode == mbrs_pkg::OP_BYTE) begin
        if (rx_count < 8'(mbrs_pkg::HDR_LEN)) begin
          header_bytes[rx_count[2:0]] <= items.rx_byte;
        end
        if (rx_count < 8'(RX_COUNT_LIMIT)) begin
          rx_count <= rx_count + 8'd1;
        end
        gap_count <= 4'd1;
      end else if (rx_count != 8'd0) begin
        if (handle) begin
          rx_count  <= 8'd0;
          gap_count <= 4'd0;
        end else begin
          gap_count <= gap_next;
        end
      end
    end
  end

endmodule

### rtl/core/mbrs_cmd_fifo.sv
module mbrs_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mbrs_pkg::cmd_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output mbrs_pkg::cmd_t head
);

  localparam int unsigned PtrW = $clog2(mbrs_pkg::CMD_DEPTH);

  mbrs_pkg::cmd_t      entries [mbrs_pkg::CMD_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [PtrW:0]       count;
  logic                do_push;
  logic                do_pop;

  assign full      = count == (PtrW+1)'(mbrs_pkg::CMD_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(mbrs_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(mbrs_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mbrs_back.sv
module mbrs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     slave_address,
  input  logic           cmd_valid,
  input  mbrs_pkg::cmd_t cmd_head,
  output logic           cmd_pop,
  mbrs_out_if.source     resp
);

  mbrs_pkg::back_state_t state;
  mbrs_pkg::back_state_t state_next;

  logic [7:0]  first_address_reg;
  logic [7:0]  second_address_reg;
  logic [7:0]  mode_reg;
  logic [3:0]  idx;
  logic [15:0] crc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        advance;
  logic        send_beat;
  logic [7:0]  cur_byte;

  assign advance     = !out_valid || resp.ready;
  assign resp.valid     = out_valid;
  assign resp.tx_byte   = out_byte;
  assign resp.last_byte = out_last;

  always_comb begin
    state_next = state;
    case (state)
      mbrs_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_head.kind == mbrs_pkg::CMD_READ) begin
          state_next = mbrs_pkg::BK_SEND;
        end
      end
      mbrs_pkg::BK_SEND: begin
        if (advance && idx == mbrs_pkg::RESP_LAST) begin
          state_next = mbrs_pkg::BK_IDLE;
        end
      end
      default: state_next = mbrs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    send_beat = 1'b0;
    case (state)
      mbrs_pkg::BK_IDLE: cmd_pop   = cmd_valid;
      mbrs_pkg::BK_SEND: send_beat = advance;
      default: begin
        cmd_pop   = 1'b0;
        send_beat = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (idx)
      4'd0:    cur_byte = slave_address;
      4'd1:    cur_byte = mbrs_pkg::FUNC_READ;
      4'd2:    cur_byte = mbrs_pkg::RESP_COUNT;
      4'd4:    cur_byte = first_address_reg;
      4'd6:    cur_byte = second_address_reg;
      4'd8:    cur_byte = mode_reg;
      4'd9:    cur_byte = crc[7:0];
      4'd10:   cur_byte = crc[15:8];
      default: cur_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= mbrs_pkg::BK_IDLE;
      first_address_reg  <= 8'd0;
      second_address_reg <= 8'd0;
      mode_reg           <= 8'd1;
      idx                <= 4'd0;
      crc                <= mbrs_pkg::CRC_INIT;
      out_valid          <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        if (cmd_head.kind == mbrs_pkg::CMD_READ) begin
          idx <= 4'd0;
          crc <= mbrs_pkg::CRC_INIT;
        end else begin
          case (cmd_head.reg_sel)
            mbrs_pkg::REG_FIRST:  first_address_reg  <= cmd_head.data;
            mbrs_pkg::REG_SECOND: second_address_reg <= cmd_head.data;
            mbrs_pkg::REG_MODE:   mode_reg           <= cmd_head.data;
            default: ;
          endcase
        end
      end
      if (send_beat) begin
        out_valid <= 1'b1;
        idx       <= idx + 4'd1;
        if (idx < mbrs_pkg::CRC_FIRST) begin
          crc <= mbrs_pkg::crc_byte(crc, cur_byte);
        end
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (send_beat) begin
      out_byte <= cur_byte;
      out_last <= idx == mbrs_pkg::RESP_LAST;
    end
  end

endmodule

### rtl/core/modbus_rtu_slave_three_registers_top.sv
// Channel  Dir  Fields                 Beat when
// items    in   opcode, rx_byte        items.valid && items.ready
// resp     out  tx_byte, last_byte     resp.valid && resp.ready
// cfg      in   index, data            cfg.valid && cfg.ready (always ready)
//
// One item per cycle while the two-entry command queue has room.
// A read request holds the response unit for 11 output beats, one per cycle
// when the sink is ready; CRC advances one byte per beat for beats 0-8.
// Synchronous active-high reset; no clearing pass.
// Input stalls only when the command queue fills behind a pending response.
module modbus_rtu_slave_three_registers_top #(
  parameter int unsigned RX_COUNT_LIMIT = 255
) (
  input logic         clk,
  input logic         rst,
  mbrs_in_if.sink     items,
  mbrs_out_if.source  resp,
  mbrs_cfg_if.sink    cfg
);

  logic [7:0]     slave_address;
  logic [3:0]     gap_threshold;
  logic           cmd_full;
  logic           cmd_push;
  logic           cmd_valid;
  logic           cmd_pop;
  mbrs_pkg::cmd_t cmd_in;
  mbrs_pkg::cmd_t cmd_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
      gap_threshold <= 4'd3;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        mbrs_pkg::CFG_SLAVE_ADDRESS: slave_address <= cfg.data;
        mbrs_pkg::CFG_GAP_THRESHOLD: gap_threshold <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  mbrs_front #(
    .RX_COUNT_LIMIT(RX_COUNT_LIMIT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .items         (items),
    .slave_address (slave_address),
    .gap_threshold (gap_threshold),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in)
  );

  mbrs_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .full      (cmd_full),
    .not_empty (cmd_valid),
    .head      (cmd_head)
  );

  mbrs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .cmd_valid     (cmd_valid),
    .cmd_head      (cmd_head),
    .cmd_pop       (cmd_pop),
    .resp          (resp)
  );

endmodule
